### rtl/hds_pkg.sv
// Shared types, widths and constant tables for the hemisphere direction sampler.
package hds_pkg;

    localparam int FRACTION_BITS = 14;
    localparam int CORDIC_STEPS  = 16;
    localparam int ONE           = 1 << FRACTION_BITS;

    localparam int SL_STEPS  = 16;
    localparam int RES_STEPS = FRACTION_BITS + 1;
    localparam int ZW        = FRACTION_BITS;
    localparam int RW        = 2 * FRACTION_BITS + 2;
    localparam int CW        = 34;
    localparam int DW        = 18;
    localparam int QW        = FRACTION_BITS + 1;
    localparam int TW        = FRACTION_BITS + 2;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;

    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001,
        32'h00000000, 32'h00000000
    };

    typedef struct packed {
        logic signed [15:0] in_dir_x;
        logic signed [15:0] in_dir_y;
        logic signed [15:0] in_dir_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic        [15:0] rand_height;
        logic        [15:0] rand_angle;
    } req_t;

    typedef struct packed {
        logic               scatter_valid;
        logic signed [15:0] out_dir_x;
        logic signed [15:0] out_dir_y;
        logic signed [15:0] out_dir_z;
    } rsp_t;

    typedef struct packed {
        logic               ok;
        logic               use_x;
        logic [1:0]         quad;
        logic [ZW-1:0]      z;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic signed [CW-1:0] cor_x;
        logic signed [CW-1:0] cor_y;
        logic signed [CW-1:0] cor_t;
        logic [RW-1:0]      r_rem;
        logic [RW-1:0]      r_res;
        logic [31:0]        l_rem;
        logic [31:0]        l_res;
        logic               sa;
        logic               sb;
        logic [15:0]        ma;
        logic [15:0]        mb;
        logic [DW-1:0]      da;
        logic [DW-1:0]      db;
        logic [QW-1:0]      qa;
        logic [QW-1:0]      qb;
        logic               ova;
        logic               ovb;
    } cell_t;

endpackage

### rtl/hds_pre.sv
// Two setup stages: dot product, local height, angle reduction and tangent selection.
module hds_pre
(
    input  logic                clk,
    input  logic                en,
    input  hds_pkg::req_t       req,
    output hds_pkg::cell_t      init
);

    localparam int TPW = 16 + hds_pkg::CW;

    typedef struct packed {
        logic signed [31:0]         pxx;
        logic signed [31:0]         pyy;
        logic signed [31:0]         pzz;
        logic [hds_pkg::ZW-1:0]     z;
        logic [2*hds_pkg::ZW-1:0]   z2;
        logic [1:0]                 quad;
        logic signed [TPW-1:0]      tprod;
        logic                       use_x;
        logic signed [31:0]         sqp;
        logic signed [31:0]         sqz;
        logic signed [15:0]         nx;
        logic signed [15:0]         ny;
        logic signed [15:0]         nz;
    } stage1_t;

    stage1_t         s1_reg, s1_next;
    hds_pkg::cell_t  init_reg, init_next;

    always_comb
    begin
        logic [hds_pkg::ZW+15:0] hz;
        logic [15:0]             asum;
        logic signed [15:0]      resid;
        logic signed [16:0]      ax_s;
        logic signed [16:0]      ay_s;
        logic [16:0]             ax;
        logic [16:0]             ay;
        logic signed [15:0]      p;
        hz             = {req.rand_height, {hds_pkg::ZW{1'b0}}};
        s1_next.z      = hz[hds_pkg::ZW+15:16];
        s1_next.z2     = s1_next.z * s1_next.z;
        asum           = req.rand_angle + 16'h2000;
        s1_next.quad   = asum[15:14];
        resid          = signed'(req.rand_angle - {asum[15:14], 14'd0});
        s1_next.tprod  = resid * hds_pkg::PI_Q30;
        s1_next.pxx    = req.in_dir_x * req.normal_x;
        s1_next.pyy    = req.in_dir_y * req.normal_y;
        s1_next.pzz    = req.in_dir_z * req.normal_z;
        ax_s           = req.normal_x;
        ay_s           = req.normal_y;
        ax             = unsigned'(ax_s[16] ? -ax_s : ax_s);
        ay             = unsigned'(ay_s[16] ? -ay_s : ay_s);
        s1_next.use_x  = ax > ay;
        p              = s1_next.use_x ? req.normal_x : req.normal_y;
        s1_next.sqp    = p * p;
        s1_next.sqz    = req.normal_z * req.normal_z;
        s1_next.nx     = req.normal_x;
        s1_next.ny     = req.normal_y;
        s1_next.nz     = req.normal_z;
    end

    always_comb
    begin
        logic signed [33:0] dot;
        logic signed [15:0] p2;
        logic signed [16:0] az_s;
        logic signed [16:0] ap_s;
        logic [16:0]        az;
        logic [16:0]        ap;
        init_next       = '0;
        dot             = 34'(s1_reg.pxx) + 34'(s1_reg.pyy) + 34'(s1_reg.pzz);
        init_next.ok    = dot[33];
        init_next.use_x = s1_reg.use_x;
        init_next.quad  = s1_reg.quad;
        init_next.z     = s1_reg.z;
        init_next.nx    = s1_reg.nx;
        init_next.ny    = s1_reg.ny;
        init_next.nz    = s1_reg.nz;
        init_next.cor_x = hds_pkg::CORDIC_GAIN;
        init_next.cor_t = hds_pkg::CW'(s1_reg.tprod >>> 15);
        init_next.r_rem = (hds_pkg::RW'(1) << (2 * hds_pkg::ZW)) - hds_pkg::RW'(s1_reg.z2);
        init_next.l_rem = unsigned'(s1_reg.sqp) + unsigned'(s1_reg.sqz);
        p2              = s1_reg.use_x ? s1_reg.nx : s1_reg.ny;
        az_s            = s1_reg.nz;
        ap_s            = p2;
        az              = unsigned'(az_s[16] ? -az_s : az_s);
        ap              = unsigned'(ap_s[16] ? -ap_s : ap_s);
        init_next.sa    = s1_reg.nz[15];
        init_next.ma    = az[15:0];
        init_next.sb    = !p2[15] && (p2 != 16'sd0);
        init_next.mb    = ap[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg   <= s1_next;
            init_reg <= init_next;
        end
    end

    assign init = init_reg;

endmodule

### rtl/hds_cell.sv
// Pipeline cell: CORDIC, two square root and divide steps, each enabled by IDX range.
module hds_cell
#(
    parameter int IDX          = 0,
    parameter int CORDIC_STEPS = hds_pkg::CORDIC_STEPS
)
(
    input  logic            clk,
    input  logic            en,
    input  hds_pkg::cell_t  prev,
    output hds_pkg::cell_t  cur
);

    localparam bit COR_ON = (IDX < CORDIC_STEPS) && (IDX < 32);
    localparam bit R_ON   = IDX < hds_pkg::RES_STEPS;
    localparam bit L_ON   = IDX < hds_pkg::SL_STEPS;
    localparam bit DIV_ON = (IDX >= hds_pkg::SL_STEPS) &&
                            (IDX < hds_pkg::SL_STEPS + hds_pkg::RES_STEPS);
    localparam bit FIRST  = IDX == hds_pkg::SL_STEPS;
    localparam int AI     = (IDX < 32) ? IDX : 31;
    localparam int RSH    = R_ON ? 2 * (hds_pkg::FRACTION_BITS - IDX) : 0;
    localparam int LSH    = L_ON ? 30 - 2 * IDX : 0;
    localparam int SH     = COR_ON ? IDX : 0;

    localparam logic signed [hds_pkg::CW-1:0] ANG  = hds_pkg::CW'(hds_pkg::ATAN_Q30[AI]);
    localparam logic [hds_pkg::RW-1:0]        RBIT = hds_pkg::RW'(1) << RSH;
    localparam logic [31:0]                   LBIT = 32'd1 << LSH;

    hds_pkg::cell_t state_reg, state_next;

    always_comb
    begin
        logic signed [hds_pkg::CW-1:0] x;
        logic signed [hds_pkg::CW-1:0] y;
        logic signed [hds_pkg::CW-1:0] t;
        logic [hds_pkg::RW-1:0]        rtrial;
        logic [31:0]                   ltrial;
        logic [hds_pkg::DW-1:0]        dv;
        logic [hds_pkg::DW-1:0]        ra;
        logic [hds_pkg::DW-1:0]        rb;
        logic [hds_pkg::DW-1:0]        ra2;
        logic [hds_pkg::DW-1:0]        rb2;
        logic                          ta;
        logic                          tb;
        state_next = prev;
        x          = prev.cor_x;
        y          = prev.cor_y;
        t          = prev.cor_t;
        rtrial     = prev.r_res + RBIT;
        ltrial     = prev.l_res + LBIT;
        dv         = hds_pkg::DW'(prev.l_res[15:0]);
        ra         = FIRST ? hds_pkg::DW'(prev.ma) : prev.da;
        rb         = FIRST ? hds_pkg::DW'(prev.mb) : prev.db;
        ta         = ra >= dv;
        tb         = rb >= dv;
        ra2        = ta ? ra - dv : ra;
        rb2        = tb ? rb - dv : rb;

        if (COR_ON)
        begin
            if (!t[hds_pkg::CW-1])
            begin
                state_next.cor_x = x - (y >>> SH);
                state_next.cor_y = y + (x >>> SH);
                state_next.cor_t = t - ANG;
            end
            else
            begin
                state_next.cor_x = x + (y >>> SH);
                state_next.cor_y = y - (x >>> SH);
                state_next.cor_t = t + ANG;
            end
        end

        if (R_ON)
        begin
            if (prev.r_rem >= rtrial)
            begin
                state_next.r_rem = prev.r_rem - rtrial;
                state_next.r_res = (prev.r_res >> 1) + RBIT;
            end
            else
            begin
                state_next.r_res = prev.r_res >> 1;
            end
        end

        if (L_ON)
        begin
            if (prev.l_rem >= ltrial)
            begin
                state_next.l_rem = prev.l_rem - ltrial;
                state_next.l_res = (prev.l_res >> 1) + LBIT;
            end
            else
            begin
                state_next.l_res = prev.l_res >> 1;
            end
        end

        if (DIV_ON)
        begin
            if (FIRST)
            begin
                state_next.ova = ra >= (dv << 1);
                state_next.ovb = rb >= (dv << 1);
            end
            state_next.da = ra2 << 1;
            state_next.db = rb2 << 1;
            state_next.qa = {prev.qa[hds_pkg::QW-2:0], ta};
            state_next.qb = {prev.qb[hds_pkg::QW-2:0], tb};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            state_reg <= state_next;
        end
    end

    assign cur = state_reg;

endmodule

### rtl/hds_post.sv
// Three finishing stages: quadrant and radius, tangent frame, and the world-space blend.
module hds_post
(
    input  logic            clk,
    input  logic            en,
    input  hds_pkg::cell_t  st,
    output hds_pkg::rsp_t   res
);

    localparam int FB  = hds_pkg::FRACTION_BITS;
    localparam int TW  = hds_pkg::TW;
    localparam int LPW = hds_pkg::QW + 1 + hds_pkg::CW;
    localparam int LXW = FB + 3;
    localparam int BPW = TW + 17;
    localparam int BW  = 19;
    localparam int OW  = 2 * FB + 24;
    localparam logic [1:0] QUAD_0   = 2'd0;
    localparam logic [1:0] QUAD_90  = 2'd1;
    localparam logic [1:0] QUAD_180 = 2'd2;
    localparam logic [1:0] QUAD_270 = 2'd3;

    typedef struct packed {
        logic                   ok;
        logic [hds_pkg::ZW-1:0] z;
        logic signed [15:0]     nx;
        logic signed [15:0]     ny;
        logic signed [15:0]     nz;
        logic signed [LPW-1:0]  lxp;
        logic signed [LPW-1:0]  lyp;
        logic signed [TW-1:0]   cx;
        logic signed [TW-1:0]   cy;
        logic signed [TW-1:0]   cz;
    } p1_t;

    typedef struct packed {
        logic                   ok;
        logic [hds_pkg::ZW-1:0] z;
        logic signed [15:0]     nx;
        logic signed [15:0]     ny;
        logic signed [15:0]     nz;
        logic signed [LXW-1:0]  lx;
        logic signed [LXW-1:0]  ly;
        logic signed [BW-1:0]   bx;
        logic signed [BW-1:0]   by;
        logic signed [BW-1:0]   bz;
        logic signed [TW-1:0]   cx;
        logic signed [TW-1:0]   cy;
        logic signed [TW-1:0]   cz;
    } p2_t;

    typedef struct packed {
        logic                 ok;
        logic signed [OW-1:0] x0;
        logic signed [OW-1:0] x1;
        logic signed [OW-1:0] x2;
        logic signed [OW-1:0] y0;
        logic signed [OW-1:0] y1;
        logic signed [OW-1:0] y2;
        logic signed [OW-1:0] z0;
        logic signed [OW-1:0] z1;
        logic signed [OW-1:0] z2;
    } p3_t;

    p1_t p1_reg, p1_next;
    p2_t p2_reg, p2_next;
    p3_t p3_reg, p3_next;

    function automatic logic signed [15:0] finish(input logic signed [OW+1:0] sum);
        logic signed [OW+1:0] sh;
        sh = sum >>> FB;
        if (sh > 32767)
            finish = 16'sh7FFF;
        else if (sh < -32768)
            finish = 16'sh8000;
        else
            finish = sh[15:0];
    endfunction

    always_comb
    begin
        logic signed [hds_pkg::QW:0]   r_s;
        logic signed [hds_pkg::CW-1:0] cs;
        logic signed [hds_pkg::CW-1:0] sn;
        logic [hds_pkg::QW-1:0]        maga;
        logic [hds_pkg::QW-1:0]        magb;
        logic signed [TW-1:0]          ma_s;
        logic signed [TW-1:0]          mb_s;
        logic signed [TW-1:0]          av;
        logic signed [TW-1:0]          bv;
        r_s = signed'({1'b0, st.r_res[hds_pkg::QW-1:0]});
        case (st.quad)
            QUAD_90:
            begin
                cs = -st.cor_y;
                sn = st.cor_x;
            end
            QUAD_180:
            begin
                cs = -st.cor_x;
                sn = -st.cor_y;
            end
            QUAD_270:
            begin
                cs = st.cor_y;
                sn = -st.cor_x;
            end
            default:
            begin
                cs = st.cor_x;
                sn = st.cor_y;
            end
        endcase
        maga = (st.ova || st.qa > hds_pkg::QW'(hds_pkg::ONE)) ? hds_pkg::QW'(hds_pkg::ONE) : st.qa;
        magb = (st.ovb || st.qb > hds_pkg::QW'(hds_pkg::ONE)) ? hds_pkg::QW'(hds_pkg::ONE) : st.qb;
        ma_s = signed'(TW'(maga));
        mb_s = signed'(TW'(magb));
        av   = st.sa ? -ma_s : ma_s;
        bv   = st.sb ? -mb_s : mb_s;
        if (st.l_res == 32'd0)
        begin
            av = '0;
            bv = '0;
        end
        p1_next.ok  = st.ok;
        p1_next.z   = st.z;
        p1_next.nx  = st.nx;
        p1_next.ny  = st.ny;
        p1_next.nz  = st.nz;
        p1_next.lxp = r_s * cs;
        p1_next.lyp = r_s * sn;
        p1_next.cx  = st.use_x ? av : '0;
        p1_next.cy  = st.use_x ? '0 : av;
        p1_next.cz  = bv;
    end

    always_comb
    begin
        logic signed [BPW-1:0] bxp;
        logic signed [BPW-1:0] byp;
        logic signed [BPW-1:0] bzp;
        bxp        = p1_reg.cy * p1_reg.nz - p1_reg.cz * p1_reg.ny;
        byp        = p1_reg.cz * p1_reg.nx - p1_reg.cx * p1_reg.nz;
        bzp        = p1_reg.cx * p1_reg.ny - p1_reg.cy * p1_reg.nx;
        p2_next.ok = p1_reg.ok;
        p2_next.z  = p1_reg.z;
        p2_next.nx = p1_reg.nx;
        p2_next.ny = p1_reg.ny;
        p2_next.nz = p1_reg.nz;
        p2_next.lx = LXW'(p1_reg.lxp >>> 30);
        p2_next.ly = LXW'(p1_reg.lyp >>> 30);
        p2_next.bx = BW'(bxp >>> FB);
        p2_next.by = BW'(byp >>> FB);
        p2_next.bz = BW'(bzp >>> FB);
        p2_next.cx = p1_reg.cx;
        p2_next.cy = p1_reg.cy;
        p2_next.cz = p1_reg.cz;
    end

    always_comb
    begin
        logic signed [hds_pkg::ZW:0] zs;
        zs         = signed'({1'b0, p2_reg.z});
        p3_next.ok = p2_reg.ok;
        p3_next.x0 = p2_reg.lx * p2_reg.bx;
        p3_next.x1 = p2_reg.ly * p2_reg.cx;
        p3_next.x2 = zs * p2_reg.nx;
        p3_next.y0 = p2_reg.lx * p2_reg.by;
        p3_next.y1 = p2_reg.ly * p2_reg.cy;
        p3_next.y2 = zs * p2_reg.ny;
        p3_next.z0 = p2_reg.lx * p2_reg.bz;
        p3_next.z1 = p2_reg.ly * p2_reg.cz;
        p3_next.z2 = zs * p2_reg.nz;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            p3_reg <= p3_next;
        end
    end

    always_comb
    begin
        logic signed [OW+1:0] sx;
        logic signed [OW+1:0] sy;
        logic signed [OW+1:0] sz;
        sx = (OW+2)'(p3_reg.x0) + (OW+2)'(p3_reg.x1) + (OW+2)'(p3_reg.x2);
        sy = (OW+2)'(p3_reg.y0) + (OW+2)'(p3_reg.y1) + (OW+2)'(p3_reg.y2);
        sz = (OW+2)'(p3_reg.z0) + (OW+2)'(p3_reg.z1) + (OW+2)'(p3_reg.z2);
        res.scatter_valid = p3_reg.ok;
        res.out_dir_x     = p3_reg.ok ? finish(sx) : '0;
        res.out_dir_y     = p3_reg.ok ? finish(sy) : '0;
        res.out_dir_z     = p3_reg.ok ? finish(sz) : '0;
    end

endmodule

### rtl/hemisphere_direction_sampler_top.sv
// A result beat passes the setup stages, the chain of NCELL cells, the finishing stages
// and the output register, where NCELL = max(CORDIC_STEPS, 16 + FRACTION_BITS + 1).
// Throughput: one beat per cycle while the skid register is empty; each cell performs
// its CORDIC step, square root steps or divide step (one bit of each tangent quotient).
// A skid register at the output takes one finished beat while the output waits.
// Reset clears only the valid flags of the pipeline, output and skid registers.
module hemisphere_direction_sampler_top
#(
    parameter int CORDIC_STEPS = hds_pkg::CORDIC_STEPS
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  hds_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output hds_pkg::rsp_t  rsp
);

    localparam int DIV_END = hds_pkg::SL_STEPS + hds_pkg::RES_STEPS;
    localparam int NCELL   = (CORDIC_STEPS > DIV_END) ? CORDIC_STEPS : DIV_END;
    localparam int P       = NCELL + 5;

    hds_pkg::cell_t chain [NCELL+1];
    hds_pkg::rsp_t  tail;
    hds_pkg::rsp_t  rsp_reg;
    hds_pkg::rsp_t  skid_reg;
    logic [P-1:0]   v_reg;
    logic           rsp_v_reg;
    logic           skid_v_reg;
    logic           en;
    logic           take_tail;
    logic           out_free;

    assign en        = !skid_v_reg;
    assign take_tail = en && v_reg[P-1];
    assign out_free  = !rsp_v_reg || rsp_ready;

    hds_pre u_pre
    (
        .clk  (clk),
        .en   (en),
        .req  (req),
        .init (chain[0])
    );

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        hds_cell
        #(
            .IDX          (i),
            .CORDIC_STEPS (CORDIC_STEPS)
        )
        u_cell
        (
            .clk  (clk),
            .en   (en),
            .prev (chain[i]),
            .cur  (chain[i+1])
        );
    end

    hds_post u_post
    (
        .clk (clk),
        .en  (en),
        .st  (chain[NCELL]),
        .res (tail)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg      <= '0;
            rsp_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                v_reg <= {v_reg[P-2:0], req_valid};
            end
            if (out_free)
            begin
                if (skid_v_reg)
                begin
                    skid_v_reg <= 1'b0;
                    rsp_v_reg  <= 1'b1;
                end
                else
                begin
                    rsp_v_reg <= take_tail;
                end
            end
            else if (take_tail)
            begin
                skid_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            rsp_reg <= skid_v_reg ? skid_reg : tail;
        end
        if (!out_free && take_tail)
        begin
            skid_reg <= tail;
        end
    end

    assign req_ready = en;
    assign rsp_valid = rsp_v_reg;
    assign rsp       = rsp_reg;

endmodule

### rtl/hds_checker.sv
// Port-level checker for the hemisphere direction sampler, bound to the top level.
module hds_checker
(
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input hds_pkg::req_t  req,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input hds_pkg::rsp_t  rsp
);

    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req))
        else $error("request beat changed while stalled");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result beat changed while stalled");

    a_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.scatter_valid |->
            rsp.out_dir_x == 16'sd0 && rsp.out_dir_y == 16'sd0 && rsp.out_dir_z == 16'sd0)
        else $error("non-scatter beat carries a direction");

    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid)
        else $error("input stalled with no result pending");

    a_stall_persists: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready && !rsp_ready |=> !req_ready)
        else $error("input reopened while the output stayed blocked");

endmodule

bind hemisphere_direction_sampler_top hds_checker u_hds_checker (.*);

### tb/sv/tb_top.sv
// Self-checking testbench for the hemisphere direction sampler: random and directed beats.
`timescale 1ns / 1ps

module tb_top;

    localparam int LATENCY = 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam longint PI_Q30_L = 64'sd3373259426;
    localparam longint GAIN_L = 64'sd652032874;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    hds_pkg::req_t req;
    logic rsp_valid;
    logic rsp_ready;
    hds_pkg::rsp_t rsp;

    hds_pkg::rsp_t expected_dirs[$];
    int mismatch_count;
    int beats_sent;
    int beats_checked;
    int valid_samples;
    int cycle_count;
    bit stall_enable;

    hemisphere_direction_sampler_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint res;
        longint bit_val;
        res = 0;
        bit_val = 64'sd1 << 62;
        while (bit_val > v)
        begin
            bit_val = bit_val >> 2;
        end
        while (bit_val != 0)
        begin
            if (v >= res + bit_val)
            begin
                v = v - (res + bit_val);
                res = (res >> 1) + bit_val;
            end
            else
            begin
                res = res >> 1;
            end
            bit_val = bit_val >> 2;
        end
        return res;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint magnitude(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic hds_pkg::rsp_t sample_direction(hds_pkg::req_t r);
        hds_pkg::rsp_t res;
        longint one;
        longint wx, wy, wz, nx, ny, nz, dotp;
        longint z, rad, theta, x, y, dx, dy, c, s, lx, ly;
        longint cx, cy, cz, bx, by, bz, sl, o;
        longint a;
        longint q;
        longint out_v [3];
        one = 64'sd1 <<< hds_pkg::FRACTION_BITS;
        wx = r.in_dir_x;
        wy = r.in_dir_y;
        wz = r.in_dir_z;
        nx = r.normal_x;
        ny = r.normal_y;
        nz = r.normal_z;
        dotp = wx * nx + wy * ny + wz * nz;
        res = '0;
        if (dotp >= 0)
        begin
            return res;
        end
        z = (longint'(r.rand_height) << hds_pkg::FRACTION_BITS) >> 16;
        rad = int_sqrt(one * one - z * z);
        a = r.rand_angle;
        q = ((a + 'h2000) >> 14) & 3;
        theta = longint'(signed'(16'((a - q * 'h4000) & 'hFFFF)));
        theta = floor_shift(theta * PI_Q30_L, 15);
        x = GAIN_L;
        y = 0;
        for (int i = 0; i < hds_pkg::CORDIC_STEPS && i < 32; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (theta >= 0)
            begin
                x = x - dx;
                y = y + dy;
                theta = theta - longint'(hds_pkg::ATAN_Q30[i]);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                theta = theta + longint'(hds_pkg::ATAN_Q30[i]);
            end
        end
        case (q)
            1: begin c = -y; s = x; end
            2: begin c = -x; s = -y; end
            3: begin c = y; s = -x; end
            default: begin c = x; s = y; end
        endcase
        lx = floor_shift(rad * c, 30);
        ly = floor_shift(rad * s, 30);
        cx = 0;
        cy = 0;
        cz = 0;
        if (magnitude(nx) > magnitude(ny))
        begin
            sl = int_sqrt(nx * nx + nz * nz);
            if (sl != 0)
            begin
                cx = (nz * one) / sl;
                cz = (-nx * one) / sl;
            end
        end
        else
        begin
            sl = int_sqrt(ny * ny + nz * nz);
            if (sl != 0)
            begin
                cy = (nz * one) / sl;
                cz = (-ny * one) / sl;
            end
        end
        cx = clamp(cx, -one, one);
        cy = clamp(cy, -one, one);
        cz = clamp(cz, -one, one);
        bx = floor_shift(cy * nz - cz * ny, hds_pkg::FRACTION_BITS);
        by = floor_shift(cz * nx - cx * nz, hds_pkg::FRACTION_BITS);
        bz = floor_shift(cx * ny - cy * nx, hds_pkg::FRACTION_BITS);
        out_v[0] = lx * bx + ly * cx + z * nx;
        out_v[1] = lx * by + ly * cy + z * ny;
        out_v[2] = lx * bz + ly * cz + z * nz;
        for (int k = 0; k < 3; k++)
        begin
            o = clamp(floor_shift(out_v[k], hds_pkg::FRACTION_BITS), -32768, 32767);
            out_v[k] = o;
        end
        res.scatter_valid = 1'b1;
        res.out_dir_x = 16'(out_v[0]);
        res.out_dir_y = 16'(out_v[1]);
        res.out_dir_z = 16'(out_v[2]);
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatch_count++;
        $display("mismatch at beat %0d: %s got %0d expected %0d", beats_checked, what, got,
                 want);
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            return 0;
        end
        if (roll < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic send_beat(hds_pkg::req_t item);
        int gap;
        gap = stall_enable ? pick_gap() : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req <= item;
        req_valid <= 1'b1;
        expected_dirs.push_back(sample_direction(item));
        @(posedge clk);
        while (!req_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        beats_sent++;
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (expected_dirs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic signed [15:0] rand_component();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
        begin
            return 16'($urandom());
        end
        if (roll == 1)
        begin
            return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
        end
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic hds_pkg::req_t random_item();
        hds_pkg::req_t item;
        real len;
        real vx, vy, vz;
        item.normal_x = rand_component();
        item.normal_y = rand_component();
        item.normal_z = rand_component();
        if ($urandom_range(0, 9) < 7)
        begin
            vx = item.normal_x;
            vy = item.normal_y;
            vz = item.normal_z;
            len = $sqrt(vx * vx + vy * vy + vz * vz);
            if (len > 0.0)
            begin
                item.normal_x = 16'($rtoi(vx * 16384.0 / len));
                item.normal_y = 16'($rtoi(vy * 16384.0 / len));
                item.normal_z = 16'($rtoi(vz * 16384.0 / len));
            end
        end
        item.in_dir_x = rand_component();
        item.in_dir_y = rand_component();
        item.in_dir_z = rand_component();
        if ($urandom_range(0, 9) < 7)
        begin
            item.in_dir_x = -item.normal_x + 16'($signed($urandom_range(0, 8000)) - 4000);
            item.in_dir_y = -item.normal_y + 16'($signed($urandom_range(0, 8000)) - 4000);
            item.in_dir_z = -item.normal_z + 16'($signed($urandom_range(0, 8000)) - 4000);
        end
        item.rand_height = 16'($urandom());
        item.rand_angle = 16'($urandom());
        return item;
    endfunction

    function automatic hds_pkg::req_t make_item(int dx, int dy, int dz, int nx, int ny,
                                                int nz, int h, int a);
        hds_pkg::req_t item;
        item.in_dir_x = 16'(dx);
        item.in_dir_y = 16'(dy);
        item.in_dir_z = 16'(dz);
        item.normal_x = 16'(nx);
        item.normal_y = 16'(ny);
        item.normal_z = 16'(nz);
        item.rand_height = 16'(h);
        item.rand_angle = 16'(a);
        return item;
    endfunction

    task automatic test_facing_and_extremes();
        send_beat(make_item(0, 0, -16384, 0, 0, 16384, 0, 0));
        send_beat(make_item(0, 0, -16384, 0, 0, 16384, 65535, 65535));
        send_beat(make_item(0, 0, 16384, 0, 0, 16384, 1000, 2000));
        send_beat(make_item(0, 0, 0, 0, 0, 16384, 1000, 2000));
        send_beat(make_item(0, 0, -16384, 0, 0, 0, 1000, 2000));
        send_beat(make_item(16384, 0, 0, -16384, 0, 0, 32768, 16384));
        send_beat(make_item(0, 16384, 0, 0, -16384, 0, 32768, 32768));
        send_beat(make_item(-32768, -32768, -32768, 32767, 32767, 32767, 65535, 49152));
        send_beat(make_item(32767, 32767, 32767, -32768, -32768, -32768, 40000, 8191));
        send_beat(make_item(-1, 0, 0, 1, 0, 0, 12345, 8192));
    endtask

    task automatic test_tangent_cases();
        send_beat(make_item(0, 0, 1, 0, 0, -1, 30000, 24576));
        send_beat(make_item(0, -5, 0, 0, 5, 0, 30000, 40960));
        send_beat(make_item(-100, 0, 0, 3, 0, 0, 50000, 57344));
        send_beat(make_item(-11585, -11585, 0, 11585, 11585, 0, 20000, 100));
        send_beat(make_item(-9459, -9459, -9459, 9459, 9459, 9459, 60000, 65000));
        send_beat(make_item(-16384, 16384, -16384, 16384, -16384, 16384, 65535, 32767));
        send_beat(make_item(-32768, 0, 0, 32767, 0, 1, 65535, 0));
        send_beat(make_item(0, 0, -16384, 20000, 20000, 16384, 65535, 16383));
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2)
            begin
                drain();
            end
            stall_enable = (n % 300) > 60;
            send_beat(random_item());
        end
        stall_enable = 1'b1;
    endtask

    initial
    begin : stall_ready
        int gap;
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            gap = 0;
            if (stall_enable && $urandom_range(0, 3) == 0)
            begin
                gap = pick_gap();
            end
            if (gap > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_ready <= 1'b1;
        end
    end

    initial
    begin : check_results
        hds_pkg::rsp_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && rsp_ready)
            begin
                if (expected_dirs.size() == 0)
                begin
                    report_mismatch("unexpected beat", 1, 0);
                end
                else
                begin
                    want = expected_dirs.pop_front();
                    if (rsp.scatter_valid !== want.scatter_valid)
                    begin
                        report_mismatch("scatter_valid", rsp.scatter_valid,
                                        want.scatter_valid);
                    end
                    if (rsp.out_dir_x !== want.out_dir_x)
                    begin
                        report_mismatch("out_dir_x", rsp.out_dir_x, want.out_dir_x);
                    end
                    if (rsp.out_dir_y !== want.out_dir_y)
                    begin
                        report_mismatch("out_dir_y", rsp.out_dir_y, want.out_dir_y);
                    end
                    if (rsp.out_dir_z !== want.out_dir_z)
                    begin
                        report_mismatch("out_dir_z", rsp.out_dir_z, want.out_dir_z);
                    end
                    if (want.scatter_valid)
                    begin
                        valid_samples++;
                    end
                end
                beats_checked++;
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("FAIL hemisphere_direction_sampler_top");
                $finish;
            end
        end
    end

    initial
    begin
        mismatch_count = 0;
        beats_sent = 0;
        beats_checked = 0;
        valid_samples = 0;
        stall_enable = 1'b1;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_facing_and_extremes();
        test_tangent_cases();
        test_random(1430);
        drain();
        $display("covered %0d request beats, %0d results checked, %0d valid scatters",
                 beats_sent, beats_checked, valid_samples);
        $display("directed facing, tangent and saturation cases plus random stalls on both sides");
        if (mismatch_count == 0 && expected_dirs.size() == 0)
        begin
            $display("PASS hemisphere_direction_sampler_top");
        end
        else
        begin
            $display("FAIL hemisphere_direction_sampler_top");
        end
        $finish;
    end

endmodule
